// ===== design/dqsc_pkg.sv =====
`default_nettype none
package dqsc_pkg;

	localparam logic [7:0] SEG_OFF = 8'hFF;

	localparam logic [2:0] STEP_0 = 3'd0;
	localparam logic [2:0] STEP_1 = 3'd1;
	localparam logic [2:0] STEP_2 = 3'd2;
	localparam logic [2:0] STEP_4 = 3'd4;

	typedef logic [3:0] digit_t;

	// active-low seven-segment codes, digits above nine show nine
	function automatic logic [7:0] seg_code(input digit_t d);
		logic [7:0] c;
		case (d)
			4'd0: c = 8'hC0;
			4'd1: c = 8'hF9;
			4'd2: c = 8'hA4;
			4'd3: c = 8'hB0;
			4'd4: c = 8'h99;
			4'd5: c = 8'h92;
			4'd6: c = 8'h82;
			4'd7: c = 8'hF8;
			4'd8: c = 8'h80;
			default: c = 8'h90;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/dual_quadrature_step_counter_unit.sv =====
// Dual quadrature step counter: each item carries two button samples and the
// A/B phases of two encoders; each item gives one result holding the wrapped
// count, its five active-low seven-segment codes and the step size. One item
// per cycle is sustained while the output does not stall; the count, step and
// debounce state are updated at acceptance, and the result passes through a
// two-entry queue and a three-stage digit pipeline (thousands, then hundreds,
// then tens and ones). Output stalls back up through the pipeline into the
// queue, and input ready drops only when the queue is full.
`default_nettype none
module dual_quadrature_step_counter_unit #(
	parameter int DEBOUNCE_LEN = 12,
	parameter int COUNT_MAX = 1023
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] button_levels,
	input  wire logic [3:0] encoder_bits,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [9:0]      shown_count,
	output logic [7:0]      seg_ones,
	output logic [7:0]      seg_tens,
	output logic [7:0]      seg_blank,
	output logic [7:0]      seg_hundreds,
	output logic [7:0]      seg_thousands,
	output logic [2:0]      step_size
);
	import dqsc_pkg::*;

	localparam int SHOWN_W = $clog2(COUNT_MAX + 1);
	localparam int ENT_W = SHOWN_W + 3;

	logic push, full, q_valid, q_ready;
	logic [SHOWN_W-1:0] f_shown;
	logic [2:0] f_step;
	logic [ENT_W-1:0] q_data;

	dqsc_front #(
		.DEBOUNCE_LEN(DEBOUNCE_LEN),
		.COUNT_MAX(COUNT_MAX),
		.SHOWN_W(SHOWN_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_levels(button_levels),
		.encoder_bits(encoder_bits),
		.full(full),
		.push(push),
		.shown(f_shown),
		.step(f_step)
	);

	dqsc_queue #(.WIDTH(ENT_W)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data({f_shown, f_step}),
		.full(full),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_data(q_data)
	);

	dqsc_back #(.SHOWN_W(SHOWN_W)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_shown(q_data[ENT_W-1:3]),
		.q_step(q_data[2:0]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.shown_count(shown_count),
		.seg_ones(seg_ones),
		.seg_tens(seg_tens),
		.seg_blank(seg_blank),
		.seg_hundreds(seg_hundreds),
		.seg_thousands(seg_thousands),
		.step_size(step_size)
	);

	a_step_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (step_size == STEP_0 || step_size == STEP_1 ||
			step_size == STEP_2 || step_size == STEP_4))
		else $error("illegal step size");

	a_blank_thou: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seg_thousands != SEG_OFF |-> seg_hundreds != SEG_OFF)
		else $error("hundreds blanked under a shown thousands digit");

	a_blank_hund: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seg_hundreds != SEG_OFF |-> seg_tens != SEG_OFF)
		else $error("tens blanked under a shown hundreds digit");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

endmodule
`default_nettype wire

// ===== design/dqsc_front.sv =====
`default_nettype none
module dqsc_front #(
	parameter int DEBOUNCE_LEN = 12,
	parameter int COUNT_MAX = 1023,
	parameter int SHOWN_W = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         button_levels,
	input  wire logic [3:0]         encoder_bits,
	input  wire logic               full,
	output logic                    push,
	output logic [SHOWN_W-1:0]      shown,
	output logic [2:0]              step
);
	import dqsc_pkg::*;

	localparam int HIST_W = DEBOUNCE_LEN + 1;
	localparam int CNT_W = $clog2(COUNT_MAX + 5) + 1;
	localparam logic [HIST_W-1:0] PRESS = HIST_W'(1) << DEBOUNCE_LEN;
	localparam logic signed [CNT_W-1:0] CMAX = CNT_W'(COUNT_MAX);

	typedef enum logic [1:0] {DIR_NONE, DIR_UP, DIR_DOWN} dir_t;

	logic [HIST_W-1:0] hist_a_q, hist_b_q, hist_a_d, hist_b_d;
	logic [2:0] step_q, step_a, step_d;
	logic [3:0] phases_q;
	logic signed [CNT_W-1:0] count_q, wrapped, count_d, step_ext;
	dir_t dir1, dir2, dir;

	function automatic dir_t enc_dir(input logic a_old, input logic b_old,
		input logic a_new, input logic b_new);
		dir_t r;
		r = DIR_NONE;
		if (a_old && a_new) begin
			if (!b_old && b_new)
				r = DIR_UP;
			else if (b_old && !b_new)
				r = DIR_DOWN;
		end
		return r;
	endfunction

	assign in_ready = !full;
	assign push = in_valid && !full;

	always_comb begin
		if (count_q > CMAX)
			wrapped = '0;
		else if (count_q < 0)
			wrapped = CMAX;
		else
			wrapped = count_q;

		hist_a_d = {hist_a_q[HIST_W-2:0], button_levels[0]};
		hist_b_d = {hist_b_q[HIST_W-2:0], button_levels[1]};

		step_a = step_q;
		if (hist_a_d == PRESS) begin
			case (step_q)
				STEP_2: step_a = STEP_1;
				STEP_0: step_a = STEP_4;
				STEP_4: step_a = STEP_0;
				default: step_a = STEP_2;
			endcase
		end
		step_d = step_a;
		if (hist_b_d == PRESS) begin
			case (step_a)
				STEP_4: step_d = STEP_1;
				STEP_0: step_d = STEP_2;
				STEP_2: step_d = STEP_0;
				default: step_d = STEP_4;
			endcase
		end

		dir1 = enc_dir(phases_q[0], phases_q[1], encoder_bits[0], encoder_bits[1]);
		dir2 = enc_dir(phases_q[2], phases_q[3], encoder_bits[2], encoder_bits[3]);
		dir = (dir2 != DIR_NONE) ? dir2 : dir1;

		step_ext = $signed({{(CNT_W-3){1'b0}}, step_d});
		case (dir)
			DIR_UP: count_d = wrapped + step_ext;
			DIR_DOWN: count_d = wrapped - step_ext;
			default: count_d = wrapped;
		endcase
	end

	assign shown = wrapped[SHOWN_W-1:0];
	assign step = step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_a_q <= '0;
			hist_b_q <= '0;
			step_q <= STEP_1;
			phases_q <= '0;
			count_q <= '0;
		end else if (push) begin
			hist_a_q <= hist_a_d;
			hist_b_q <= hist_b_d;
			step_q <= step_d;
			phases_q <= encoder_bits;
			count_q <= count_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/dqsc_queue.sv =====
`default_nettype none
module dqsc_queue #(
	parameter int WIDTH = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic pop;

	assign full = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign pop = rd_valid && rd_ready;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/dqsc_back.sv =====
`default_nettype none
module dqsc_back #(
	parameter int SHOWN_W = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	output logic                    q_ready,
	input  wire logic [SHOWN_W-1:0] q_shown,
	input  wire logic [2:0]         q_step,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [9:0]              shown_count,
	output logic [7:0]              seg_ones,
	output logic [7:0]              seg_tens,
	output logic [7:0]              seg_blank,
	output logic [7:0]              seg_hundreds,
	output logic [7:0]              seg_thousands,
	output logic [2:0]              step_size
);
	import dqsc_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	digit_t th_c, hu_c, te_c, on_c;
	logic [SHOWN_W-1:0] rem1_c, rem2_c;

	digit_t th_s1, th_s2, hu_s2;
	logic [SHOWN_W-1:0] rem_s1, rem_s2;
	logic [9:0] shown_s1, shown_s2, shown_s3;
	logic [2:0] step_s1, step_s2, step_s3;
	logic [7:0] ones_s3, tens_s3, hund_s3, thou_s3;

	assign rdy_s3 = !v_s3 || out_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign q_ready = rdy_s1;

	// decimal digits by parallel compares: thousands, hundreds, then tens and ones
	always_comb begin
		th_c = '0;
		for (int k = 1; k < 10; k++)
			if (32'(q_shown) >= k * 1000)
				th_c = digit_t'(k);
		rem1_c = SHOWN_W'(32'(q_shown) - 32'(th_c) * 1000);

		hu_c = '0;
		for (int k = 1; k < 10; k++)
			if (32'(rem_s1) >= k * 100)
				hu_c = digit_t'(k);
		rem2_c = SHOWN_W'(32'(rem_s1) - 32'(hu_c) * 100);

		te_c = '0;
		for (int k = 1; k < 10; k++)
			if (32'(rem_s2) >= k * 10)
				te_c = digit_t'(k);
		on_c = digit_t'(32'(rem_s2) - 32'(te_c) * 10);
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			th_s1 <= th_c;
			rem_s1 <= rem1_c;
			shown_s1 <= 10'(q_shown);
			step_s1 <= q_step;
		end
		if (rdy_s2) begin
			th_s2 <= th_s1;
			hu_s2 <= hu_c;
			rem_s2 <= rem2_c;
			shown_s2 <= shown_s1;
			step_s2 <= step_s1;
		end
		if (rdy_s3) begin
			shown_s3 <= shown_s2;
			step_s3 <= step_s2;
			ones_s3 <= seg_code(on_c);
			tens_s3 <= (th_s2 == '0 && hu_s2 == '0 && te_c == '0) ? SEG_OFF : seg_code(te_c);
			hund_s3 <= (th_s2 == '0 && hu_s2 == '0) ? SEG_OFF : seg_code(hu_s2);
			thou_s3 <= (th_s2 == '0) ? SEG_OFF : seg_code(th_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= q_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_s3)
				v_s3 <= v_s2;
		end
	end

	assign out_valid = v_s3;
	assign shown_count = shown_s3;
	assign seg_ones = ones_s3;
	assign seg_tens = tens_s3;
	assign seg_blank = SEG_OFF;
	assign seg_hundreds = hund_s3;
	assign seg_thousands = thou_s3;
	assign step_size = step_s3;

endmodule
`default_nettype wire
